### rtl/hfm_pkg.sv
// Shared constants, types and saturating helpers for the HLL moving-interface flux core.
// Used by every module of the block; depends on nothing else.
package hfm_pkg;

  localparam int DW = 48;
  localparam int FB = 24;
  localparam int GW = 26;
  localparam logic [GW-1:0] GAMMA_RESET = GW'(23488102);

  localparam int MUL_LO = DW / 2;
  localparam int MUL_HI = DW - MUL_LO;

  localparam int SQ_XW = 2 * ((DW + FB + 1) / 2);
  localparam int SQ_RB = SQ_XW / 2;

  localparam int LAT_MUL = 3;
  localparam int LAT_DIV = DW + 2;
  localparam int LAT_SQRT = SQ_RB + 1;
  localparam int LAT_LANE = 2 * LAT_DIV + 3 * LAT_MUL + LAT_SQRT;
  localparam int LAT_MERGE = LAT_MUL + 2;
  localparam int LAT_TOTAL = LAT_LANE + LAT_MERGE;

  typedef logic signed [DW-1:0] data_t;
  typedef logic [DW-1:0] umag_t;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_RHO  = 2'd1,
    ST_PRES = 2'd2
  } status_t;

  typedef struct packed {
    data_t rho;
    data_t m;
    data_t e;
    data_t u;
    data_t v;
    data_t c;
    data_t f0;
    data_t f1;
    data_t f2;
    logic  rho_ok;
    logic  p_ok;
  } lane_out_t;

  localparam umag_t VMAX = {1'b0, {(DW-1){1'b1}}};

  function automatic umag_t mag(data_t a);
    umag_t ua;
    ua = umag_t'(a);
    return ua[DW-1] ? (~ua + 1'b1) : ua;
  endfunction

  function automatic data_t sat_add(data_t a, data_t b);
    logic signed [DW:0] s;
    s = {a[DW-1], a} + {b[DW-1], b};
    if (s[DW] != s[DW-1]) begin
      return s[DW] ? data_t'({1'b1, {(DW-1){1'b0}}}) : data_t'(VMAX);
    end
    return data_t'(s[DW-1:0]);
  endfunction

  function automatic data_t sat_sub(data_t a, data_t b);
    logic signed [DW:0] s;
    s = {a[DW-1], a} - {b[DW-1], b};
    if (s[DW] != s[DW-1]) begin
      return s[DW] ? data_t'({1'b1, {(DW-1){1'b0}}}) : data_t'(VMAX);
    end
    return data_t'(s[DW-1:0]);
  endfunction

  function automatic data_t half_tz(data_t x);
    data_t t;
    t = x + data_t'({{(DW-1){1'b0}}, x[DW-1]});
    return data_t'(t >>> 1);
  endfunction

endpackage

### rtl/hfm_fmul.sv
// Three-stage signed fixed-point multiplier with truncation and saturation.
// Uses hfm_pkg; the product is built from four half-width partial products.
module hfm_fmul import hfm_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  logic  half,
  input  data_t a,
  input  data_t b,
  output data_t p
);

  logic [MUL_LO-1:0] al, bl;
  logic [MUL_HI-1:0] ah, bh;
  umag_t ma_r, mb_r;
  logic neg_r, half_r, neg2_r, half2_r;
  logic [2*MUL_LO-1:0] pp0_r;
  logic [MUL_LO+MUL_HI-1:0] pp1_r, pp2_r;
  logic [2*MUL_HI-1:0] pp3_r;
  logic [2*DW-1:0] prod, shf;
  umag_t lim, mg;
  data_t p_r;

  assign al = ma_r[MUL_LO-1:0];
  assign ah = ma_r[DW-1:MUL_LO];
  assign bl = mb_r[MUL_LO-1:0];
  assign bh = mb_r[DW-1:MUL_LO];

  always_comb begin
    prod = (2*DW)'(pp0_r) + ((2*DW)'(pp1_r) << MUL_LO) + ((2*DW)'(pp2_r) << MUL_LO)
         + ((2*DW)'(pp3_r) << (2*MUL_LO));
    shf = half2_r ? (prod >> (FB + 1)) : (prod >> FB);
    lim = VMAX + umag_t'(neg2_r);
    mg = (shf > (2*DW)'(lim)) ? lim : shf[DW-1:0];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ma_r <= mag(a);
      mb_r <= mag(b);
      neg_r <= a[DW-1] ^ b[DW-1];
      half_r <= half;
      pp0_r <= al * bl;
      pp1_r <= al * bh;
      pp2_r <= ah * bl;
      pp3_r <= ah * bh;
      neg2_r <= neg_r;
      half2_r <= half_r;
      p_r <= neg2_r ? data_t'(~mg + 1'b1) : data_t'(mg);
    end
  end

  assign p = p_r;

endmodule

### rtl/hfm_fdiv.sv
// Pipelined restoring divider for fixed-point quotients, one quotient bit per stage.
// Uses hfm_pkg; a zero divisor gives zero, an oversize quotient saturates.
module hfm_fdiv import hfm_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  data_t a,
  input  data_t b,
  output data_t q
);

  localparam int RW = DW + 1;
  localparam int XW = DW + FB;

  umag_t ma, md;
  logic [XW-1:0] xw;
  logic [RW-1:0] rem_r [DW+1];
  umag_t xs_r [DW+1];
  umag_t q_r [DW+1];
  umag_t md_r [DW+1];
  logic neg_r [DW+1];
  logic ovf_r [DW+1];
  logic zero_r [DW+1];
  logic [RW-1:0] r2 [DW];
  logic [RW-1:0] rn [DW];
  logic qb [DW];
  umag_t lim, mg;
  data_t q_o_r;

  always_comb begin
    ma = mag(a);
    md = mag(b);
    xw = {ma, {FB{1'b0}}};
    for (int k = 0; k < DW; k++) begin
      r2[k] = {rem_r[k][RW-2:0], xs_r[k][DW-1]};
      qb[k] = r2[k] >= RW'(md_r[k]);
      rn[k] = qb[k] ? (r2[k] - RW'(md_r[k])) : r2[k];
    end
    lim = VMAX + umag_t'(neg_r[DW]);
    mg = (ovf_r[DW] || (q_r[DW] > lim)) ? lim : q_r[DW];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem_r[0] <= RW'(xw[XW-1:DW]);
      xs_r[0] <= xw[DW-1:0];
      q_r[0] <= '0;
      md_r[0] <= md;
      neg_r[0] <= a[DW-1] ^ b[DW-1];
      ovf_r[0] <= RW'(xw[XW-1:DW]) >= RW'(md);
      zero_r[0] <= (md == '0);
      for (int k = 0; k < DW; k++) begin
        rem_r[k+1] <= rn[k];
        xs_r[k+1] <= xs_r[k] << 1;
        q_r[k+1] <= {q_r[k][DW-2:0], qb[k]};
        md_r[k+1] <= md_r[k];
        neg_r[k+1] <= neg_r[k];
        ovf_r[k+1] <= ovf_r[k];
        zero_r[k+1] <= zero_r[k];
      end
      if (zero_r[DW]) begin
        q_o_r <= '0;
      end else begin
        q_o_r <= neg_r[DW] ? data_t'(~mg + 1'b1) : data_t'(mg);
      end
    end
  end

  assign q = q_o_r;

endmodule

### rtl/hfm_fsqrt.sv
// Pipelined integer square root of a fixed-point value, one root bit per stage.
// Uses hfm_pkg; nonpositive operands give zero.
module hfm_fsqrt import hfm_pkg::*; (
  input  logic  clk,
  input  logic  en,
  input  data_t a,
  output data_t r
);

  localparam int REMW = SQ_RB + 3;

  logic [SQ_XW-1:0] x_r [SQ_RB+1];
  logic [REMW-1:0] rem_r [SQ_RB+1];
  logic [SQ_RB-1:0] root_r [SQ_RB+1];
  logic [REMW-1:0] r2 [SQ_RB];
  logic [REMW-1:0] tr [SQ_RB];
  logic rb [SQ_RB];

  always_comb begin
    for (int k = 0; k < SQ_RB; k++) begin
      r2[k] = {rem_r[k][REMW-3:0], x_r[k][SQ_XW-1:SQ_XW-2]};
      tr[k] = REMW'({root_r[k], 2'b01});
      rb[k] = r2[k] >= tr[k];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r[0] <= (a > 0) ? SQ_XW'({a, {FB{1'b0}}}) : '0;
      rem_r[0] <= '0;
      root_r[0] <= '0;
      for (int k = 0; k < SQ_RB; k++) begin
        x_r[k+1] <= x_r[k] << 2;
        rem_r[k+1] <= rb[k] ? (r2[k] - tr[k]) : r2[k];
        root_r[k+1] <= {root_r[k][SQ_RB-2:0], rb[k]};
      end
    end
  end

  assign r = data_t'(root_r[SQ_RB]);

endmodule

### rtl/hfm_lane.sv
// One side of the interface: velocity, pressure, sound speed and physical fluxes.
// Uses hfm_pkg, hfm_fdiv, hfm_fmul and hfm_fsqrt; two copies run side by side.
module hfm_lane import hfm_pkg::*; (
  input  logic          clk,
  input  logic          en,
  input  logic [GW-1:0] gamma,
  input  data_t         rho,
  input  data_t         m,
  input  data_t         e,
  input  data_t         u,
  output lane_out_t     lo
);

  localparam int LEN_C = LAT_DIV + LAT_MUL + LAT_SQRT;
  localparam int LEN_G = LEN_C - LAT_MUL - 1;

  typedef struct packed {
    data_t rho;
    data_t m;
    data_t e;
    data_t u;
    data_t v;
  } st_t;

  typedef struct packed {
    st_t  s;
    logic rho_ok;
    logic p_ok;
  } hold_t;

  typedef struct packed {
    data_t f0;
    data_t f1;
    data_t f2;
  } flux_t;

  data_t gm1, gma, v, vm, e_int, p, w, pdr, g, c;
  data_t pm0, pm1, pm2, pm3;
  st_t a_in, a_o, b_in, b_o, c_o;
  st_t da_r [LAT_DIV];
  st_t db_r [LAT_MUL];
  st_t dc_r [LAT_MUL];
  data_t df_r [LAT_MUL];
  flux_t f_r;
  flux_t dg_r [LEN_G];
  hold_t h_in;
  hold_t dh_r [LEN_C];

  assign gma = data_t'({{(DW-GW){1'b0}}, gamma});
  assign gm1 = gma - data_t'({{(DW-FB-1){1'b0}}, 1'b1, {FB{1'b0}}});

  assign a_in = '{rho: rho, m: m, e: e, u: u, v: '0};
  assign a_o = da_r[LAT_DIV-1];
  assign b_in = '{rho: a_o.rho, m: a_o.m, e: a_o.e, u: a_o.u, v: v};
  assign b_o = db_r[LAT_MUL-1];
  assign c_o = dc_r[LAT_MUL-1];
  assign e_int = sat_sub(b_o.e, vm);
  assign w = sat_sub(c_o.v, c_o.u);
  assign h_in = '{s: c_o, rho_ok: (c_o.rho > 0), p_ok: (p > 0)};

  hfm_fdiv u_div_v (.clk(clk), .en(en), .a(m), .b(rho), .q(v));
  hfm_fmul u_mul_vm (.clk(clk), .en(en), .half(1'b1), .a(v), .b(a_o.m), .p(vm));
  hfm_fmul u_mul_p (.clk(clk), .en(en), .half(1'b0), .a(gm1), .b(e_int), .p(p));
  hfm_fdiv u_div_pr (.clk(clk), .en(en), .a(p), .b(c_o.rho), .q(pdr));
  hfm_fmul u_mul_g (.clk(clk), .en(en), .half(1'b0), .a(gma), .b(pdr), .p(g));
  hfm_fsqrt u_sqrt (.clk(clk), .en(en), .a(g), .r(c));
  hfm_fmul u_mul_f0 (.clk(clk), .en(en), .half(1'b0), .a(c_o.rho), .b(w), .p(pm0));
  hfm_fmul u_mul_f1 (.clk(clk), .en(en), .half(1'b0), .a(c_o.m), .b(w), .p(pm1));
  hfm_fmul u_mul_f2 (.clk(clk), .en(en), .half(1'b0), .a(c_o.e), .b(w), .p(pm2));
  hfm_fmul u_mul_pv (.clk(clk), .en(en), .half(1'b0), .a(p), .b(c_o.v), .p(pm3));

  always_ff @(posedge clk) begin
    if (en) begin
      da_r[0] <= a_in;
      for (int i = 1; i < LAT_DIV; i++) da_r[i] <= da_r[i-1];
      db_r[0] <= b_in;
      dc_r[0] <= b_o;
      df_r[0] <= p;
      for (int i = 1; i < LAT_MUL; i++) begin
        db_r[i] <= db_r[i-1];
        dc_r[i] <= dc_r[i-1];
        df_r[i] <= df_r[i-1];
      end
      f_r.f0 <= pm0;
      f_r.f1 <= sat_add(pm1, df_r[LAT_MUL-1]);
      f_r.f2 <= sat_add(pm2, pm3);
      dg_r[0] <= f_r;
      for (int i = 1; i < LEN_G; i++) dg_r[i] <= dg_r[i-1];
      dh_r[0] <= h_in;
      for (int i = 1; i < LEN_C; i++) dh_r[i] <= dh_r[i-1];
    end
  end

  always_comb begin
    lo.rho = dh_r[LEN_C-1].s.rho;
    lo.m = dh_r[LEN_C-1].s.m;
    lo.e = dh_r[LEN_C-1].s.e;
    lo.u = dh_r[LEN_C-1].s.u;
    lo.v = dh_r[LEN_C-1].s.v;
    lo.c = c;
    lo.f0 = dg_r[LEN_G-1].f0;
    lo.f1 = dg_r[LEN_G-1].f1;
    lo.f2 = dg_r[LEN_G-1].f2;
    lo.rho_ok = dh_r[LEN_C-1].rho_ok;
    lo.p_ok = dh_r[LEN_C-1].p_ok;
  end

endmodule

### rtl/hfm_merge.sv
// Merging stage: wave-speed bound, upwind or HLL selection and the status code.
// Uses hfm_pkg and hfm_fmul; takes the two lane results for the same word.
module hfm_merge import hfm_pkg::*; (
  input  logic      clk,
  input  logic      en,
  input  lane_out_t ll,
  input  lane_out_t lr,
  output data_t     mass_flux,
  output data_t     momentum_flux,
  output data_t     energy_flux,
  output status_t   status
);

  typedef struct packed {
    logic [2:0][DW-1:0] hs;
    logic [2:0][DW-1:0] fl;
    logic [2:0][DW-1:0] fr;
    logic               ge;
    logic               le;
    status_t            st;
  } hold_t;

  umag_t mvl, mvr, mvx;
  data_t vm, cm, s, ns;
  data_t fl [3];
  data_t fr [3];
  data_t ul [3];
  data_t ur [3];
  data_t t [3];
  data_t res [3];
  status_t st;
  data_t s_r, u_r;
  data_t du_r [3];
  hold_t h_in;
  hold_t d_r [LAT_MUL];
  hold_t h_o;
  data_t out_r [3];
  status_t st_out_r;

  always_comb begin
    fl = '{ll.f0, ll.f1, ll.f2};
    fr = '{lr.f0, lr.f1, lr.f2};
    ul = '{ll.rho, ll.m, ll.e};
    ur = '{lr.rho, lr.m, lr.e};
    mvl = mag(ll.v);
    mvr = mag(lr.v);
    mvx = (mvl > mvr) ? mvl : mvr;
    vm = (mvx > VMAX) ? data_t'(VMAX) : data_t'(mvx);
    cm = (ll.c > lr.c) ? ll.c : lr.c;
    s = sat_add(vm, cm);
    if (!(ll.rho_ok && lr.rho_ok)) begin
      st = ST_RHO;
    end else if (!(ll.p_ok && lr.p_ok)) begin
      st = ST_PRES;
    end else begin
      st = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s_r <= s;
      u_r <= ll.u;
      for (int i = 0; i < 3; i++) begin
        du_r[i] <= sat_sub(ur[i], ul[i]);
        h_in.hs[i] <= sat_add(half_tz(fl[i]), half_tz(fr[i]));
        h_in.fl[i] <= fl[i];
        h_in.fr[i] <= fr[i];
      end
      h_in.st <= st;
    end
  end

  assign ns = -s_r;

  always_ff @(posedge clk) begin
    if (en) begin
      d_r[0] <= '{hs: h_in.hs, fl: h_in.fl, fr: h_in.fr, ge: (u_r >= s_r), le: (u_r <= ns),
                  st: h_in.st};
      for (int i = 1; i < LAT_MUL; i++) d_r[i] <= d_r[i-1];
    end
  end

  assign h_o = d_r[LAT_MUL-1];

  hfm_fmul u_mul_t0 (.clk(clk), .en(en), .half(1'b0), .a(s_r), .b(du_r[0]), .p(t[0]));
  hfm_fmul u_mul_t1 (.clk(clk), .en(en), .half(1'b0), .a(s_r), .b(du_r[1]), .p(t[1]));
  hfm_fmul u_mul_t2 (.clk(clk), .en(en), .half(1'b0), .a(s_r), .b(du_r[2]), .p(t[2]));

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      if (h_o.st != ST_OK) begin
        res[i] = '0;
      end else if (h_o.ge) begin
        res[i] = data_t'(h_o.fr[i]);
      end else if (h_o.le) begin
        res[i] = data_t'(h_o.fl[i]);
      end else begin
        res[i] = sat_sub(data_t'(h_o.hs[i]), half_tz(t[i]));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int i = 0; i < 3; i++) out_r[i] <= res[i];
      st_out_r <= h_o.st;
    end
  end

  assign mass_flux = out_r[0];
  assign momentum_flux = out_r[1];
  assign energy_flux = out_r[2];
  assign status = st_out_r;

endmodule

### rtl/hll_flux_moving_interface_core.sv
// Top level of the HLL moving-interface flux core: lanes, merge and flow control.
// Uses hfm_pkg, hfm_lane and hfm_merge.
//
//   port group   direction  handshake        word
//   in_*         input      valid / stall    two conserved states and interface speed
//   out_*        output     valid / stall    three fluxes and a status code
//   cfg_*        input      valid / ready    heat capacity ratio
//
// One word is accepted every cycle while in_stall is low; the pipeline depth is set by
// the two bit-per-stage dividers and the bit-per-stage square root in each lane.
// Reset is synchronous and active low; it empties the pipeline and restores gamma to 1.4.
// The whole pipeline advances whenever the output register is empty or being taken,
// so a stall on the output holds every stage and raises in_stall in the same cycle.
module hll_flux_moving_interface_core import hfm_pkg::*; (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  data_t         in_left_density,
  input  data_t         in_left_momentum,
  input  data_t         in_left_energy,
  input  data_t         in_right_density,
  input  data_t         in_right_momentum,
  input  data_t         in_right_energy,
  input  data_t         in_interface_velocity,
  output logic          out_valid,
  input  logic          out_stall,
  output data_t         out_mass_flux,
  output data_t         out_momentum_flux,
  output data_t         out_energy_flux,
  output logic [1:0]    out_status,
  input  logic          cfg_valid,
  output logic          cfg_ready,
  input  logic [GW-1:0] cfg_data
);

  logic en;
  logic [GW-1:0] gamma_r;
  logic vld_r [LAT_TOTAL];
  lane_out_t lo_l, lo_r;
  status_t st;

  assign en = !vld_r[LAT_TOTAL-1] || !out_stall;
  assign in_stall = !en;
  assign out_valid = vld_r[LAT_TOTAL-1];
  assign cfg_ready = 1'b1;
  assign out_status = st;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gamma_r <= GAMMA_RESET;
    end else if (cfg_valid) begin
      gamma_r <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT_TOTAL; i++) vld_r[i] <= 1'b0;
    end else if (en) begin
      vld_r[0] <= in_valid;
      for (int i = 1; i < LAT_TOTAL; i++) vld_r[i] <= vld_r[i-1];
    end
  end

  hfm_lane u_lane_l (
    .clk(clk), .en(en), .gamma(gamma_r),
    .rho(in_left_density), .m(in_left_momentum), .e(in_left_energy),
    .u(in_interface_velocity), .lo(lo_l)
  );

  hfm_lane u_lane_r (
    .clk(clk), .en(en), .gamma(gamma_r),
    .rho(in_right_density), .m(in_right_momentum), .e(in_right_energy),
    .u(in_interface_velocity), .lo(lo_r)
  );

  hfm_merge u_merge (
    .clk(clk), .en(en), .ll(lo_l), .lr(lo_r),
    .mass_flux(out_mass_flux), .momentum_flux(out_momentum_flux),
    .energy_flux(out_energy_flux), .status(st)
  );

endmodule

### sim/tb.sv
// Self-checking testbench for hll_flux_moving_interface_core: predicts HLL fluxes and compares.
// Depends on hfm_pkg and the RTL top level; no files or arguments are read.
`timescale 1ns / 100ps

module tb import hfm_pkg::*; ();

  localparam longint VMX = (64'sd1 <<< (DW - 1)) - 1;
  localparam longint VMN = -VMX - 1;
  localparam longint ONE = 64'sd1 <<< FB;
  localparam int CYCLE_LIMIT = 2000000;

  typedef struct {
    data_t f[7];
  } flux_word_t;

  typedef struct {
    data_t  mass;
    data_t  mom;
    data_t  ener;
    status_t st;
  } flux_result_t;

  class flux_scoreboard;
    flux_result_t pending_fluxes[$];
    int errors = 0;

    function longint clamp_mag(bit neg, logic [127:0] w);
      longint lim;
      longint mg;
      lim = VMX + (neg ? 1 : 0);
      mg = (w > 128'(lim)) ? lim : longint'(w[63:0]);
      return neg ? -mg : mg;
    endfunction

    function longint absv(longint a);
      return a < 0 ? -a : a;
    endfunction

    function longint sadd(longint a, longint b);
      longint s;
      s = a + b;
      return s > VMX ? VMX : (s < VMN ? VMN : s);
    endfunction

    function longint ssub(longint a, longint b);
      return sadd(a, -b);
    endfunction

    function longint fmul(longint a, longint b, int sh);
      logic [127:0] w;
      w = (128'(absv(a)) * 128'(absv(b))) >> sh;
      return clamp_mag((a < 0) != (b < 0), w);
    endfunction

    function longint fdiv(longint a, longint b);
      logic [127:0] w;
      if (b == 0) return 0;
      w = (128'(absv(a)) << FB) / 128'(absv(b));
      return clamp_mag((a < 0) != (b < 0), w);
    endfunction

    function longint fsqrt(longint a);
      logic [127:0] x;
      logic [127:0] r;
      logic [127:0] c;
      if (a <= 0) return 0;
      x = 128'(a) << FB;
      r = 0;
      for (int i = 40; i >= 0; i--) begin
        c = r | (128'd1 << i);
        if (c * c <= x) r = c;
      end
      return clamp_mag(1'b0, r);
    endfunction

    function flux_result_t predict_flux(flux_word_t w, longint gamma);
      flux_result_t r;
      longint rho[2], m[2], e[2], v[2], p[2], c[2], f[2][3];
      longint u, s, vm, t, gm1;
      gm1 = gamma - ONE;
      u = longint'(w.f[6]);
      r = '{default: 0, st: ST_OK};
      for (int k = 0; k < 2; k++) begin
        rho[k] = longint'(w.f[3*k]);
        m[k] = longint'(w.f[3*k+1]);
        e[k] = longint'(w.f[3*k+2]);
        v[k] = 0;
        p[k] = 0;
        if (rho[k] > 0) begin
          v[k] = fdiv(m[k], rho[k]);
          p[k] = fmul(gm1, ssub(e[k], fmul(v[k], m[k], FB + 1)), FB);
        end
      end
      if (rho[0] <= 0 || rho[1] <= 0) begin
        r.st = ST_RHO;
        return r;
      end
      if (p[0] <= 0 || p[1] <= 0) begin
        r.st = ST_PRES;
        return r;
      end
      for (int k = 0; k < 2; k++) begin
        c[k] = fsqrt(fmul(gamma, fdiv(p[k], rho[k]), FB));
        t = ssub(v[k], u);
        f[k][0] = fmul(rho[k], t, FB);
        f[k][1] = sadd(fmul(m[k], t, FB), p[k]);
        f[k][2] = sadd(fmul(e[k], t, FB), fmul(p[k], v[k], FB));
      end
      vm = absv(v[0]) > absv(v[1]) ? absv(v[0]) : absv(v[1]);
      if (vm > VMX) vm = VMX;
      s = sadd(vm, c[0] > c[1] ? c[0] : c[1]);
      for (int i = 0; i < 3; i++) begin
        longint res;
        longint d;
        if (u >= s) begin
          res = f[1][i];
        end else if (u <= -s) begin
          res = f[0][i];
        end else begin
          d = (i == 0) ? ssub(rho[1], rho[0]) : (i == 1) ? ssub(m[1], m[0]) : ssub(e[1], e[0]);
          t = fmul(s, d, FB);
          res = ssub(sadd(f[0][i] / 2, f[1][i] / 2), t / 2);
        end
        if (i == 0) r.mass = data_t'(res);
        else if (i == 1) r.mom = data_t'(res);
        else r.ener = data_t'(res);
      end
      return r;
    endfunction

    function void note_word(flux_word_t w, longint gamma);
      pending_fluxes.push_back(predict_flux(w, gamma));
    endfunction

    function void check_word(data_t mass, data_t mom, data_t ener, logic [1:0] st);
      flux_result_t x;
      if (pending_fluxes.size() == 0) begin
        $display("%0t: unexpected result word", $time);
        errors++;
        return;
      end
      x = pending_fluxes.pop_front();
      if (mass !== x.mass) begin
        $display("%0t: mass flux exp %0d got %0d", $time, x.mass, mass);
        errors++;
      end
      if (mom !== x.mom) begin
        $display("%0t: momentum flux exp %0d got %0d", $time, x.mom, mom);
        errors++;
      end
      if (ener !== x.ener) begin
        $display("%0t: energy flux exp %0d got %0d", $time, x.ener, ener);
        errors++;
      end
      if (st !== x.st) begin
        $display("%0t: status exp %0d got %0d", $time, x.st, st);
        errors++;
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  data_t in_f[7];
  logic out_valid;
  logic out_stall = 1'b1;
  data_t out_mass_flux, out_momentum_flux, out_energy_flux;
  logic [1:0] out_status;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [GW-1:0] cfg_data = '0;

  flux_scoreboard sb = new();
  longint gamma_now = longint'(GAMMA_RESET);
  bit quiet = 1'b0;
  int cycles = 0;

  initial begin
    for (int i = 0; i < 7; i++) in_f[i] = '0;
  end

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  hll_flux_moving_interface_core dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall),
    .in_left_density(in_f[0]), .in_left_momentum(in_f[1]), .in_left_energy(in_f[2]),
    .in_right_density(in_f[3]), .in_right_momentum(in_f[4]), .in_right_energy(in_f[5]),
    .in_interface_velocity(in_f[6]),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_mass_flux(out_mass_flux), .out_momentum_flux(out_momentum_flux),
    .out_energy_flux(out_energy_flux), .out_status(out_status),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    int n;
    @(posedge clk);
    while (rst_n !== 1'b1) @(posedge clk);
    forever begin
      n = quiet ? 0 : $urandom_range(0, 8);
      if (n > 0) begin
        out_stall <= 1'b1;
        repeat (n) @(posedge clk);
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
      sb.check_word(out_mass_flux, out_momentum_flux, out_energy_flux, out_status);
    end
  end

  task automatic send_word(flux_word_t w);
    int gap;
    gap = quiet ? 0 : $urandom_range(0, 8);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    for (int i = 0; i < 7; i++) in_f[i] <= w.f[i];
    in_valid <= 1'b1;
    do @(posedge clk); while (in_stall);
    sb.note_word(w, gamma_now);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (sb.pending_fluxes.size() != 0) @(posedge clk);
    repeat (LAT_TOTAL + 20) @(posedge clk);
  endtask

  task automatic write_gamma(logic [GW-1:0] g);
    cfg_data <= g;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    gamma_now = longint'(g);
  endtask

  function automatic data_t rnd48();
    return data_t'({$urandom, $urandom});
  endfunction

  function automatic flux_word_t make_word(data_t a, data_t b, data_t c, data_t d,
                                           data_t e, data_t f, data_t g);
    flux_word_t w;
    w.f = '{a, b, c, d, e, f, g};
    return w;
  endfunction

  function automatic flux_word_t random_word();
    flux_word_t w;
    longint rho, vel, mom, en, u;
    if ($urandom_range(0, 9) < 2) begin
      for (int i = 0; i < 7; i++) w.f[i] = rnd48();
      return w;
    end
    for (int k = 0; k < 2; k++) begin
      rho = $urandom_range(1 << 16, 1 << 28);
      vel = longint'($urandom_range(0, 16 << 24)) - (8 << 24);
      mom = (rho * vel) >>> FB;
      en = ((mom * vel) >>> (FB + 1)) + longint'($urandom_range(0, 1 << 30));
      if ($urandom_range(0, 19) == 0) en = en - longint'($urandom_range(0, 1 << 30));
      w.f[3*k] = data_t'(rho);
      w.f[3*k+1] = data_t'(mom);
      w.f[3*k+2] = data_t'(en);
    end
    case ($urandom_range(0, 3))
      0: u = longint'($urandom_range(0, 64 << 24)) - (32 << 24);
      1: u = longint'(rnd48());
      default: u = longint'($urandom_range(0, 8 << 24)) - (4 << 24);
    endcase
    w.f[6] = data_t'(u);
    return w;
  endfunction

  task automatic directed_words();
    data_t mx, mn, o;
    mx = data_t'(VMX);
    mn = data_t'(VMN);
    o = data_t'(ONE);
    send_word(make_word(mx, mx, mx, mx, mx, mx, mx));
    send_word(make_word(mn, mn, mn, mn, mn, mn, mn));
    send_word(make_word(0, 0, o, o, 0, o, 0));
    send_word(make_word(o, 0, o, -o, 0, o, 0));
    send_word(make_word(o, 0, 0, o, 0, o, 0));
    send_word(make_word(o, o, -o, o, 0, o, 0));
    send_word(make_word(mx, 0, 3, mx, 0, 3, 0));
    send_word(make_word(mx, 0, 3, mx, 0, 3, -1));
    send_word(make_word(o, o, 4 * o, 2 * o, -o, 5 * o, 0));
    send_word(make_word(o, o, 4 * o, 2 * o, -o, 5 * o, mx));
    send_word(make_word(o, o, 4 * o, 2 * o, -o, 5 * o, mn));
    send_word(make_word(o, o, 4 * o, 2 * o, -o, 5 * o, 100 * o));
    send_word(make_word(o, o, 4 * o, 2 * o, -o, 5 * o, -100 * o));
    send_word(make_word(1, mx, mx, 1, mn, mx, 0));
    send_word(make_word(mx, mx, mx, 1, 0, mx, o));
    send_word(make_word(o, mn, mx, o, mx, mx, 0));
  endtask

  initial begin
    logic [GW-1:0] gammas[6];
    int per_phase;
    gammas = '{GW'(50331648), GW'(16777216), '1, GW'(12582912), GW'(20971520), GAMMA_RESET};
    per_phase = 120;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    directed_words();
    for (int i = 0; i < per_phase; i++) send_word(random_word());
    for (int ph = 0; ph < 6; ph++) begin
      drain();
      write_gamma(gammas[ph]);
      quiet = (ph == 4);
      directed_words();
      for (int i = 0; i < per_phase; i++) begin
        if (ph == 2 && i == per_phase / 2) drain();
        send_word(random_word());
      end
    end
    quiet = 1'b0;
    in_valid <= 1'b0;
    while (sb.pending_fluxes.size() != 0) @(posedge clk);
    repeat (LAT_TOTAL + 20) @(posedge clk);
    if (sb.errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

### filelist.f
rtl/hfm_pkg.sv
rtl/hfm_fmul.sv
rtl/hfm_fdiv.sv
rtl/hfm_fsqrt.sv
rtl/hfm_lane.sv
rtl/hfm_merge.sv
rtl/hll_flux_moving_interface_core.sv
sim/tb.sv
